/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the bit reader.
// Each macro places one labeled concurrent assertion that is disabled while rstn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent hold in the same cycle.
`define MSBR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define MSBR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/msbr_pkg.sv */
// Package of the MSB-first bit reader: sizes, mode codes and shared structs.
// Used by msbr_core, the top level and the checker; depends on nothing.
`default_nettype none

package msbr_pkg;

  localparam int BUF_BYTES     = 4096;
  localparam int ADDR_W        = $clog2(BUF_BYTES);
  localparam int CNT_W         = ADDR_W + 1;
  localparam int CAP_BITS      = BUF_BYTES * 8;
  localparam int POS_W         = 16;
  localparam int MAX_READ_BITS = 64;
  localparam int RCNT_W        = 7;
  localparam int NB_W          = 4;
  localparam int ACC_W         = 72;
  localparam int IDX_W         = 14;
  localparam int VALUE_W       = 64;
  localparam int BLEN_W        = 13;
  localparam int MODE_W        = 3;
  localparam int BYTE_W        = 8;
  localparam int OFF_W         = 12;

  localparam logic [MODE_W-1:0] MODE_LOAD    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_READ    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SKIP    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TAKE    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RESTART = 3'd4;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic [OFF_W-1:0]   byte_offset;
    logic [POS_W-1:0]   bit_position;
    logic               overrun;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

/* rtl/msbr_ram.sv */
// Generic synchronous RAM with one write port and one registered read port.
// Self-contained; sized by its WIDTH and DEPTH parameters.
`default_nettype none

module msbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/msbr_core.sv */
// Sequencer of the bit reader: holds the position and fill count, runs each mode
// and gathers read bytes from the byte memory. Depends on msbr_pkg.
`default_nettype none

module msbr_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [msbr_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [msbr_pkg::BYTE_W-1:0]    in_data_byte,
  input  wire logic [msbr_pkg::POS_W-1:0]     in_bit_count,
  input  wire logic [msbr_pkg::BLEN_W-1:0]    in_byte_len,
  output logic                                res_valid,
  input  wire logic                           res_take,
  output msbr_pkg::res_t                      res,
  output msbr_pkg::ram_req_t                  ram_req,
  input  wire logic [msbr_pkg::BYTE_W-1:0]    ram_rdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_ALIGN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam int P1 = msbr_pkg::POS_W + 1;
  localparam int P2 = msbr_pkg::POS_W + 2;
  localparam logic [msbr_pkg::POS_W-1:0] CAP   = msbr_pkg::POS_W'(msbr_pkg::CAP_BITS);
  localparam logic [P1-1:0]              CAP17 = P1'(msbr_pkg::CAP_BITS);
  localparam logic [P2-1:0]              CAP18 = P2'(msbr_pkg::CAP_BITS);

  logic [2:0] state_r, state_nxt;
  logic [msbr_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [msbr_pkg::CNT_W-1:0] loaded_r, loaded_nxt;

  logic [msbr_pkg::MODE_W-1:0]  mode_r;
  logic [msbr_pkg::BYTE_W-1:0]  data_r;
  logic [msbr_pkg::POS_W-1:0]   count_r;
  logic [msbr_pkg::BLEN_W-1:0]  blen_r;

  logic [msbr_pkg::RCNT_W-1:0]  rcnt_r, rcnt_nxt;
  logic [msbr_pkg::NB_W-1:0]    nbytes_r, nbytes_nxt;
  logic [msbr_pkg::NB_W-1:0]    issued_r, issued_nxt;
  logic [msbr_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic                         pend_r, pend_nxt;
  logic                         pend_zero_r, pend_zero_nxt;
  logic [msbr_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [2:0]                   trail_r, trail_nxt;
  msbr_pkg::res_t               res_r, res_nxt;

  logic [msbr_pkg::POS_W-1:0]   avail;
  logic [msbr_pkg::RCNT_W-1:0]  rc;
  logic [msbr_pkg::RCNT_W-1:0]  rsum;
  logic [msbr_pkg::RCNT_W-1:0]  rsum7;
  logic [P1-1:0]                rend;
  logic [P1-1:0]                send;
  logic [P2-1:0]                tend;
  logic [msbr_pkg::CNT_W-1:0]   tstart;
  logic [msbr_pkg::CNT_W:0]     tlast;
  logic [msbr_pkg::ACC_W-1:0]   shifted;
  logic [msbr_pkg::VALUE_W:0]   mask;

  always_comb begin
    avail  = {loaded_r[msbr_pkg::CNT_W-1:0], 3'b000};
    rc     = (count_r > msbr_pkg::POS_W'(msbr_pkg::MAX_READ_BITS))
             ? msbr_pkg::RCNT_W'(msbr_pkg::MAX_READ_BITS)
             : count_r[msbr_pkg::RCNT_W-1:0];
    rsum   = msbr_pkg::RCNT_W'(pos_r[2:0]) + rc;
    rsum7  = rsum + msbr_pkg::RCNT_W'(7);
    rend   = {1'b0, pos_r} + P1'(rc);
    send   = {1'b0, pos_r} + {1'b0, count_r};
    tend   = {2'b00, pos_r} + P2'({blen_r, 3'b000});
    tstart = pos_r[msbr_pkg::POS_W-1:3];
    tlast  = {1'b0, tstart} + {1'b0, blen_r};
    shifted = acc_r >> trail_r;
    mask    = ((msbr_pkg::VALUE_W + 1)'(1) << rcnt_r) - (msbr_pkg::VALUE_W + 1)'(1);
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    loaded_nxt    = loaded_r;
    rcnt_nxt      = rcnt_r;
    nbytes_nxt    = nbytes_r;
    issued_nxt    = issued_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    pend_zero_nxt = pend_zero_r;
    acc_nxt       = acc_r;
    trail_nxt     = trail_r;
    res_nxt       = res_r;
    ram_req.we    = 1'b0;
    ram_req.waddr = loaded_r[msbr_pkg::ADDR_W-1:0];
    ram_req.wdata = data_r;
    ram_req.raddr = idx_r[msbr_pkg::ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt              = '0;
        res_nxt.bit_position = pos_r;
        state_nxt            = S_DONE;
        unique case (mode_r)
          msbr_pkg::MODE_LOAD: begin
            if (loaded_r[msbr_pkg::ADDR_W]) begin
              res_nxt.overrun = 1'b1;
            end else begin
              ram_req.we = 1'b1;
              loaded_nxt = loaded_r + msbr_pkg::CNT_W'(1);
            end
          end
          msbr_pkg::MODE_READ: begin
            pos_nxt              = (rend > CAP17) ? CAP : rend[msbr_pkg::POS_W-1:0];
            res_nxt.bit_position = pos_nxt;
            res_nxt.overrun      = (rc != '0) && (rend > {1'b0, avail});
            rcnt_nxt             = rc;
            nbytes_nxt           = msbr_pkg::NB_W'(rsum7 >> 3);
            trail_nxt            = 3'd0 - rsum[2:0];
            issued_nxt           = '0;
            idx_nxt              = msbr_pkg::IDX_W'(tstart);
            acc_nxt              = '0;
            state_nxt            = S_READ;
          end
          msbr_pkg::MODE_SKIP: begin
            pos_nxt              = (send > CAP17) ? CAP : send[msbr_pkg::POS_W-1:0];
            res_nxt.bit_position = pos_nxt;
            res_nxt.overrun      = send > {1'b0, avail};
          end
          msbr_pkg::MODE_TAKE: begin
            pos_nxt              = (tend > CAP18) ? CAP : tend[msbr_pkg::POS_W-1:0];
            res_nxt.bit_position = pos_nxt;
            res_nxt.byte_offset  = tstart[msbr_pkg::OFF_W-1:0];
            res_nxt.overrun      = tstart[msbr_pkg::ADDR_W] || (tlast > {1'b0, loaded_r});
          end
          msbr_pkg::MODE_RESTART: begin
            pos_nxt              = '0;
            loaded_nxt           = '0;
            res_nxt.bit_position = '0;
          end
          default: begin
          end
        endcase
      end
      S_READ: begin
        if (pend_r) begin
          acc_nxt = {acc_r[msbr_pkg::ACC_W-msbr_pkg::BYTE_W-1:0],
                     pend_zero_r ? msbr_pkg::BYTE_W'(0) : ram_rdata};
        end
        if (issued_r != nbytes_r) begin
          pend_nxt      = 1'b1;
          pend_zero_nxt = idx_r >= msbr_pkg::IDX_W'(loaded_r);
          idx_nxt       = idx_r + msbr_pkg::IDX_W'(1);
          issued_nxt    = issued_r + msbr_pkg::NB_W'(1);
        end else if (!pend_r) begin
          state_nxt = S_ALIGN;
        end
      end
      S_ALIGN: begin
        res_nxt.read_value = shifted[msbr_pkg::VALUE_W-1:0] & mask[msbr_pkg::VALUE_W-1:0];
        state_nxt          = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pos_r    <= '0;
      loaded_r <= '0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      loaded_r <= loaded_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      mode_r  <= in_mode;
      data_r  <= in_data_byte;
      count_r <= in_bit_count;
      blen_r  <= in_byte_len;
    end
    rcnt_r      <= rcnt_nxt;
    nbytes_r    <= nbytes_nxt;
    issued_r    <= issued_nxt;
    idx_r       <= idx_nxt;
    pend_zero_r <= pend_zero_nxt;
    acc_r       <= acc_nxt;
    trail_r     <= trail_nxt;
    res_r       <= res_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

`default_nettype wire

/* rtl/msb_first_bit_reader_unit.sv */
// An MSB-first bit reader over a byte buffer loaded one byte per transaction.
// A transaction loads a byte, reads 0 to 64 bits, skips bits, takes a byte block
// or restarts, and yields exactly one result transaction. Loads, skips, block
// takes, restarts and unused modes go from the execute state straight to the
// done state, from which the result moves into the output register. A read of
// c bits (c clamped to 64) at bit offset o within its first byte fetches
// ceil((o + c) / 8) bytes, up to nine, one per cycle from the single-read-port
// byte memory, and then passes an align state before the done state. One
// transaction is in work at a time; the next is accepted in the cycle after the
// previous result has moved into the output register, even while that result is
// still waiting for out_ready. No clearing pass follows reset.
// Depends on msbr_pkg, msbr_ram and msbr_core.
`default_nettype none

module msb_first_bit_reader_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [msbr_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [msbr_pkg::BYTE_W-1:0]    in_data_byte,
  input  wire logic [msbr_pkg::POS_W-1:0]     in_bit_count,
  input  wire logic [msbr_pkg::BLEN_W-1:0]    in_byte_len,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [msbr_pkg::VALUE_W-1:0]        out_read_value,
  output logic [msbr_pkg::OFF_W-1:0]          out_byte_offset,
  output logic [msbr_pkg::POS_W-1:0]          out_bit_position,
  output logic                                out_overrun
);

  msbr_pkg::res_t              res;
  msbr_pkg::res_t              out_r;
  msbr_pkg::ram_req_t          ram_req;
  logic [msbr_pkg::BYTE_W-1:0] ram_rdata;
  logic                        res_valid;
  logic                        res_take;
  logic                        out_valid_r, out_valid_nxt;

  msbr_ram #(
    .WIDTH (msbr_pkg::BYTE_W),
    .DEPTH (msbr_pkg::BUF_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  msbr_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_data_byte (in_data_byte),
    .in_bit_count (in_bit_count),
    .in_byte_len  (in_byte_len),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res          (res),
    .ram_req      (ram_req),
    .ram_rdata    (ram_rdata)
  );

  assign res_take = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_value   = out_r.read_value;
  assign out_byte_offset  = out_r.byte_offset;
  assign out_bit_position = out_r.bit_position;
  assign out_overrun      = out_r.overrun;

endmodule

`default_nettype wire

/* rtl/msbr_checker.sv */
// Port-level checker for the bit reader, bound to the top level.
// Depends on assert_macros.svh and msbr_pkg.
`default_nettype none
`include "assert_macros.svh"

module msbr_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [msbr_pkg::VALUE_W-1:0]   out_read_value,
  input wire logic [msbr_pkg::OFF_W-1:0]     out_byte_offset,
  input wire logic [msbr_pkg::POS_W-1:0]     out_bit_position
);

  `MSBR_ASSERT_NOW(a_offset_value_excl, clk, rst_n, out_valid && out_byte_offset != '0, out_read_value == '0, "byte offset and read value set together")
  `MSBR_ASSERT_NOW(a_position_cap, clk, rst_n, out_valid, out_bit_position <= msbr_pkg::POS_W'(msbr_pkg::CAP_BITS), "bit position beyond capacity")
  `MSBR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_read_value) && $stable(out_bit_position), "stalled result transaction changed")

endmodule

bind msb_first_bit_reader_unit msbr_checker u_msbr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_read_value   (out_read_value),
  .out_byte_offset  (out_byte_offset),
  .out_bit_position (out_bit_position)
);

`default_nettype wire
